@@ rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

	localparam int DATA_W       = 32;
	localparam int OP_W         = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_OUT_W  = 5;
	localparam int CAPACITY_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Contents of one cell as seen by its neighbors.
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] data;
	} link_t;

	// Broadcast command to every cell.
	typedef struct packed {
		logic                     enq;
		logic                     deq;
		logic                     order_mode;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	// True when a is served strictly before b.
	function automatic logic outranks(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b, input logic order_mode);
		outranks = order_mode ? (a > b) : (a < b);
	endfunction

endpackage
`default_nettype wire

@@ rtl/spq_if.sv @@
`default_nettype none
interface spq_in_if;
	logic                                     valid;
	logic                                     ready;
	logic [spq_pkg::OP_W-1:0]                 opcode;
	logic signed [spq_pkg::DATA_W-1:0]        value;
	modport source (output valid, opcode, value, input ready);
	modport sink   (input valid, opcode, value, output ready);
endinterface

interface spq_out_if;
	logic                                     valid;
	logic                                     ready;
	logic [spq_pkg::STATUS_W-1:0]             status;
	logic signed [spq_pkg::DATA_W-1:0]        head_value;
	logic [spq_pkg::COUNT_OUT_W-1:0]          entry_count;
	logic                                     is_empty;
	modport source (output valid, status, head_value, entry_count, is_empty, input ready);
	modport sink   (input valid, status, head_value, entry_count, is_empty, output ready);
endinterface

interface spq_cfg_if;
	logic valid;
	logic ready;
	logic order_mode;
	modport source (output valid, order_mode, input ready);
	modport sink   (input valid, order_mode, output ready);
endinterface
`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
`default_nettype none
// Sorted priority queue of signed 32-bit values, built as a row of cells.
//
// in_ch  : one operation per transfer (opcode, value). Enqueue inserts the
//          value behind all entries of equal priority; dequeue pops the head;
//          peek reads the head in place; opcode 3 does nothing.
// out_ch : one result per operation (status, head_value, entry_count,
//          is_empty), taken from a single output register.
// cfg    : order_mode write, always ready. 0 serves smaller values first,
//          1 larger. Stored entries keep their places on a change.
// Latency: the result is valid the cycle after the operation transfer.
// Throughput: one operation per cycle unless out_ch stalls. Every cell compares
//          the incoming value with its entry at once; the insert point is the first
//          cell whose compare hits, found through a ripple chain along the row.
// Reset: queue empty, order_mode 0, no result pending.
// Stall: while out_ch is stalled with a result held, in_ch is not ready;
//          a result taken in the same cycle frees the register for the next.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	spq_in_if.sink     in_ch,
	spq_out_if.source  out_ch,
	spq_cfg_if.sink    cfg
);
	localparam int CW = $clog2(CAPACITY + 1);

	logic                  order_mode_q;
	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	spq_pkg::status_t      status_q;
	logic signed [spq_pkg::DATA_W-1:0] head_q;
	logic [spq_pkg::COUNT_OUT_W-1:0]   entry_count_q;
	logic                  is_empty_q;

	spq_pkg::link_t        links [CAPACITY];
	logic [CAPACITY:0]     found;
	spq_pkg::cmd_t         cmd;

	logic                  accept;
	spq_pkg::op_t          op;
	logic                  full, empty;
	logic                  enq_ok, deq_ok, rd_ok;
	logic [CW-1:0]         count_nxt;
	logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_ext;
	spq_pkg::status_t      status_nxt;

	// Configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			order_mode_q <= cfg.order_mode;
		end
	end

	// Operation decode
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign op          = spq_pkg::op_t'(in_ch.opcode);
	assign full        = (count_q == CW'(CAPACITY));
	assign empty       = (count_q == '0);
	assign enq_ok      = accept && (op == spq_pkg::OP_ENQ) && !full;
	assign rd_ok       = accept && (op == spq_pkg::OP_DEQ || op == spq_pkg::OP_PEEK) && !empty;
	assign deq_ok      = rd_ok && (op == spq_pkg::OP_DEQ);

	assign cmd = '{enq: enq_ok, deq: deq_ok, order_mode: order_mode_q, value: in_ch.value};

	always_comb begin
		unique case (op)
			spq_pkg::OP_ENQ:  status_nxt = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_OK;
			spq_pkg::OP_DEQ,
			spq_pkg::OP_PEEK: status_nxt = empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_OK;
			default:          status_nxt = spq_pkg::ST_OK;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (enq_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (deq_ok) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// Count reported modulo 32
	assign count_ext = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_nxt};

	// Row of cells; found ripples from the head toward the tail
	assign found[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		spq_pkg::link_t left_l, right_l;
		if (i == 0) begin : g_head
			assign left_l = '0;
		end else begin : g_mid_l
			assign left_l = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_l = '0;
		end else begin : g_mid_r
			assign right_l = links[i+1];
		end
		spq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.left      (left_l),
			.right     (right_l),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.here      (links[i])
		);
	end

	// Count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_nxt;
			head_q        <= rd_ok ? links[0].data : '0;
			entry_count_q <= count_ext[spq_pkg::COUNT_OUT_W-1:0];
			is_empty_q    <= (count_nxt == '0);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = status_q;
	assign out_ch.head_value  = head_q;
	assign out_ch.entry_count = entry_count_q;
	assign out_ch.is_empty    = is_empty_q;
endmodule
`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none
module spq_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spq_pkg::cmd_t  cmd,
	input  wire spq_pkg::link_t left,
	input  wire spq_pkg::link_t right,
	input  wire logic           found_in,
	output logic                found_out,
	output spq_pkg::link_t      here
);
	logic                             valid_q;
	logic signed [spq_pkg::DATA_W-1:0] data_q;
	logic                             hit;

	// Insertion point: first empty cell or first entry the new value outranks.
	assign hit       = !valid_q || spq_pkg::outranks(cmd.value, data_q, cmd.order_mode);
	assign found_out = found_in || hit;
	assign here      = '{valid: valid_q, data: data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.enq) begin
			if (found_in) begin
				valid_q <= left.valid;
			end else if (hit) begin
				valid_q <= 1'b1;
			end
		end else if (cmd.deq) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (found_in) begin
				data_q <= left.data;
			end else if (hit) begin
				data_q <= cmd.value;
			end
		end else if (cmd.deq) begin
			data_q <= right.data;
		end
	end
endmodule
`default_nettype wire

@@ rtl/spq_checker.sv @@
`default_nettype none
module spq_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic [spq_pkg::STATUS_W-1:0]      status,
	input wire logic [spq_pkg::DATA_W-1:0]        head_value,
	input wire logic [spq_pkg::COUNT_OUT_W-1:0]   entry_count,
	input wire logic                              is_empty
);
	// One result per transfer, valid in the following cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after operation transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(head_value) && $stable(status))
		else $error("stalled result changed");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> entry_count == '0)
		else $error("empty flag with nonzero count");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_UNDERFLOW |-> is_empty && head_value == '0)
		else $error("underflow on non-empty queue");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_OVERFLOW |-> !is_empty && head_value == '0)
		else $error("overflow on empty queue");
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.status      (out_ch.status),
	.head_value  (out_ch.head_value),
	.entry_count (out_ch.entry_count),
	.is_empty    (out_ch.is_empty)
);
`default_nettype wire
